// File: sv/servo_ease_in_out_profile_defines.svh
// Assertion macros used by the checker of the servo profile block.
`ifndef SERVO_EASE_IN_OUT_PROFILE_DEFINES_SVH
`define SERVO_EASE_IN_OUT_PROFILE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SEIO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define SEIO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/seio_pkg.sv
package seio_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 1'd1;

    localparam logic [15:0] PULSE_MIN_RST = 16'd1000;
    localparam logic [15:0] PULSE_MAX_RST = 16'd2000;

    localparam logic [7:0] ANGLE_SPAN = 8'd180;

    // divider: 24-bit dividend, 16-bit divisor, reciprocal scaled by 2^24
    localparam int unsigned DIV_DVD_W = 24;
    localparam int unsigned DIV_DVS_W = 16;
    localparam logic [31:0] DIV_UNIT  = 32'd1 << DIV_DVD_W;

    typedef enum logic [1:0] {
        DIV_WAIT,   // duration / step count
        DIV_POS,    // eased numerator / step count squared
        DIV_MAP     // |angle * pulse span| / 180
    } t_div_sel;

    typedef struct packed {
        logic     load_start;
        logic     dec_wait;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_wait;
        logic     calc_f;
        logic     take_pos;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic wait_gt1;
        logic is_last;
        logic out_free;
    } t_sts;

endpackage

// File: sv/seio_if.sv
interface seio_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  start_angle;
    logic [7:0]  end_angle;
    logic [15:0] duration_ms;

    modport source (output valid, output opcode, output start_angle, output end_angle,
                    output duration_ms, input ready);
    modport sink   (input valid, input opcode, input start_angle, input end_angle,
                    input duration_ms, output ready);
endinterface

interface seio_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_value;
    logic [7:0]  step_number;
    logic        last_step;

    modport source (output valid, output compare_value, output step_number,
                    output last_step, input ready);
    modport sink   (input valid, input compare_value, input step_number,
                    input last_step, output ready);
endinterface

// File: sv/servo_ease_in_out_profile.sv
// Servo ease-in-out motion sequencer. A start transaction (opcode 0) latches
// start and end angles (clamped to 180) and a duration, and emits step 0 of a
// quadratic ease-in-out profile at once; each later millisecond tick
// transaction (opcode 1) counts down duration/STEP_COUNT ticks (at least one)
// before emitting the next step, up to step STEP_COUNT, which carries
// last_step. Each result holds the timer compare value for the eased angle,
// mapped linearly from 0..180 degrees onto pulse_min_count..pulse_max_count
// (config index 0 and 1, reset 1000 and 2000; write them only while idle).
// A start during a move restarts it; ticks while idle give nothing.
// One transaction at a time. Every step runs two divisions (position by
// STEP_COUNT squared, pulse offset by 180) on one shared divider (operand
// latch, reciprocal multiply, back multiply, one correction), and a start
// adds a third for the step spacing. The result sits in an output register,
// so the next transaction is taken while it waits; a step only stalls if the
// previous result is still held when the new one is ready.
module servo_ease_in_out_profile #(
    parameter int unsigned STEP_COUNT = 200
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    seio_in_if.sink                        i_in,
    seio_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [seio_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                    i_cfg_data
);
    import seio_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: on a start the spacing divide, then F, position divide, pulse divide, emit
    seio_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: move state, ease arithmetic, shared divider, output register
    seio_dp #(
        .STEP_COUNT (STEP_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_start_angle   (i_in.start_angle),
        .i_end_angle     (i_in.end_angle),
        .i_duration_ms   (i_in.duration_ms),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_compare_value (o_out.compare_value),
        .o_step_number   (o_out.step_number),
        .o_last_step     (o_out.last_step)
    );
endmodule

// File: sv/seio_div.sv
module seio_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [seio_pkg::DIV_DVD_W-1:0] i_dividend,
    input  logic [seio_pkg::DIV_DVS_W-1:0] i_divisor,
    input  logic [seio_pkg::DIV_DVD_W-1:0] i_recip,
    output logic                           o_done,
    output logic [seio_pkg::DIV_DVD_W-1:0] o_quo
);
    import seio_pkg::*;

    logic [2:0]             r_stage;
    logic                   r_done;
    logic [DIV_DVD_W-1:0]   r_dvd;
    logic [DIV_DVS_W-1:0]   r_dvs;
    logic [DIV_DVD_W-1:0]   r_rcp;
    logic [DIV_DVD_W-1:0]   r_q0;
    logic [DIV_DVD_W-1:0]   r_back;
    logic [DIV_DVD_W-1:0]   r_quo;

    logic [2*DIV_DVD_W-1:0] w_prod;
    logic [DIV_DVD_W-1:0]   w_back;
    logic [DIV_DVD_W-1:0]   w_rem;
    logic                   w_fix;

    // recip = floor(2^24 / divisor); for a dividend below 2^24 the
    // estimate is the quotient or one below it, so one compare fixes it
    assign w_prod = {{DIV_DVD_W{1'b0}}, r_dvd} * {{DIV_DVD_W{1'b0}}, r_rcp};
    assign w_back = r_q0 * {{(DIV_DVD_W-DIV_DVS_W){1'b0}}, r_dvs};
    assign w_rem  = r_dvd - r_back;
    assign w_fix  = (w_rem >= {{(DIV_DVD_W-DIV_DVS_W){1'b0}}, r_dvs});

    // stages: operands in, estimate, back product, corrected quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
            r_done  <= r_stage[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rcp <= i_recip;
        end
        if (r_stage[0]) begin
            r_q0 <= w_prod[2*DIV_DVD_W-1:DIV_DVD_W];
        end
        if (r_stage[1]) begin
            r_back <= w_back;
        end
        if (r_stage[2]) begin
            r_quo <= w_fix ? (r_q0 + DIV_DVD_W'(1)) : r_q0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: sv/seio_ctrl.sv
module seio_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_opcode,
    output logic           o_in_ready,
    input  seio_pkg::t_sts i_sts,
    output seio_pkg::t_cmd o_cmd
);
    import seio_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WDIV,
        ST_FCALC,
        ST_NUM,
        ST_PDIV,
        ST_PROD,
        ST_QDIV,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_moving;
    logic   n_moving;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_moving = r_moving;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_opcode == OP_START) begin
                        o_cmd.load_start = 1'b1;
                        o_cmd.div_start  = 1'b1;
                        o_cmd.div_sel    = DIV_WAIT;
                        n_moving         = 1'b1;
                        n_state          = ST_WDIV;
                    end else if (r_moving) begin
                        if (i_sts.wait_gt1) begin
                            o_cmd.dec_wait = 1'b1;
                        end else begin
                            n_state = ST_FCALC;
                        end
                    end
                end
            end
            ST_WDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.take_wait = 1'b1;
                    n_state         = ST_FCALC;
                end
            end
            ST_FCALC: begin
                o_cmd.calc_f = 1'b1;
                n_state      = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_POS;
                n_state         = ST_PDIV;
            end
            ST_PDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.take_pos = 1'b1;
                    n_state        = ST_PROD;
                end
            end
            ST_PROD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MAP;
                n_state         = ST_QDIV;
            end
            ST_QDIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.is_last) begin
                        n_moving = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_moving <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_moving <= n_moving;
        end
    end
endmodule

// File: sv/seio_dp.sv
module seio_dp #(
    parameter int unsigned STEP_COUNT = 200
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  seio_pkg::t_cmd                    i_cmd,
    output seio_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [seio_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [15:0]                       i_cfg_data,
    input  logic [7:0]                        i_start_angle,
    input  logic [7:0]                        i_end_angle,
    input  logic [15:0]                       i_duration_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [15:0]                       o_compare_value,
    output logic [7:0]                        o_step_number,
    output logic                              o_last_step
);
    import seio_pkg::*;

    localparam int unsigned SQ     = STEP_COUNT * STEP_COUNT;
    localparam logic [15:0] SQ_W16 = 16'(SQ);
    localparam logic [19:0] SQ_W20 = 20'(SQ);
    localparam logic [19:0] FOUR_S = 20'(4 * STEP_COUNT);
    localparam logic [8:0]  S_W9   = 9'(STEP_COUNT);
    localparam logic [7:0]  S_W8   = 8'(STEP_COUNT);

    // reciprocals of the three divisors, scaled by 2^24
    localparam logic [DIV_DVD_W-1:0] RCP_S    = DIV_DVD_W'(DIV_UNIT / STEP_COUNT);
    localparam logic [DIV_DVD_W-1:0] RCP_SQ   = DIV_DVD_W'(DIV_UNIT / SQ);
    localparam logic [DIV_DVD_W-1:0] RCP_SPAN = DIV_DVD_W'(DIV_UNIT / 32'(ANGLE_SPAN));

    logic [15:0] r_min;
    logic [15:0] r_max;
    logic [7:0]  r_from;
    logic [7:0]  r_to;
    logic [15:0] r_step_wait;
    logic [15:0] r_wait_cnt;
    logic [7:0]  r_step_idx;
    logic [15:0] r_f;
    logic [7:0]  r_pos;
    logic        r_neg;
    logic        r_out_valid;
    logic [15:0] r_cmp;
    logic [7:0]  r_step_num;
    logic        r_last;

    logic [19:0]           w_ii;
    logic [19:0]           w_f_lo;
    logic [19:0]           w_f_hi;
    logic [23:0]           w_base;
    logic signed [8:0]     w_ang_diff;
    logic signed [25:0]    w_ease_prod;
    logic signed [25:0]    w_num;
    logic signed [16:0]    w_pulse_diff;
    logic signed [24:0]    w_map_prod;
    logic [24:0]           w_map_abs;
    logic [DIV_DVD_W-1:0]  w_dvd;
    logic [DIV_DVS_W-1:0]  w_dvs;
    logic [DIV_DVD_W-1:0]  w_rcp;
    logic                  w_div_done;
    logic [DIV_DVD_W-1:0]  w_quo;
    logic [15:0]           w_q16;
    logic                  w_is_last;

    // ease numerator: 2i^2 in the first half, 4iS - S^2 - 2i^2 in the second
    assign w_ii   = {12'd0, r_step_idx} * {12'd0, r_step_idx};
    assign w_f_lo = w_ii << 1;
    assign w_f_hi = FOUR_S * {12'd0, r_step_idx} - SQ_W20 - w_f_lo;

    // from*S^2 + (to-from)*F, never negative
    assign w_base      = {16'd0, r_from} * {8'd0, SQ_W16};
    assign w_ang_diff  = $signed({1'b0, r_to}) - $signed({1'b0, r_from});
    assign w_ease_prod = 26'(w_ang_diff) * 26'($signed({1'b0, r_f}));
    assign w_num       = $signed({2'b00, w_base}) + w_ease_prod;

    // angle times signed pulse span, split into sign and magnitude
    assign w_pulse_diff = $signed({1'b0, r_max}) - $signed({1'b0, r_min});
    assign w_map_prod   = 25'($signed({1'b0, r_pos})) * 25'(w_pulse_diff);
    assign w_map_abs    = w_map_prod[24] ? 25'(-w_map_prod) : 25'(w_map_prod);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_WAIT: begin
                w_dvd = {8'd0, i_duration_ms};
                w_dvs = {8'd0, S_W8};
                w_rcp = RCP_S;
            end
            DIV_POS: begin
                w_dvd = w_num[23:0];
                w_dvs = SQ_W16;
                w_rcp = RCP_SQ;
            end
            DIV_MAP: begin
                w_dvd = w_map_abs[23:0];
                w_dvs = {8'd0, ANGLE_SPAN};
                w_rcp = RCP_SPAN;
            end
            default: begin
                w_dvd = '0;
                w_dvs = SQ_W16;
                w_rcp = RCP_SQ;
            end
        endcase
    end

    seio_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_recip    (w_rcp),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    assign w_q16     = w_quo[15:0];
    assign w_is_last = (r_step_idx >= S_W8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= PULSE_MIN_RST;
            r_max       <= PULSE_MAX_RST;
            r_from      <= '0;
            r_to        <= '0;
            r_step_wait <= '0;
            r_wait_cnt  <= '0;
            r_step_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PULSE_MIN: r_min <= i_cfg_data;
                    CFG_PULSE_MAX: r_max <= i_cfg_data;
                endcase
            end
            if (i_cmd.load_start) begin
                r_from     <= (i_start_angle > ANGLE_SPAN) ? ANGLE_SPAN : i_start_angle;
                r_to       <= (i_end_angle > ANGLE_SPAN) ? ANGLE_SPAN : i_end_angle;
                r_step_idx <= '0;
            end
            if (i_cmd.take_wait) begin
                r_step_wait <= w_q16;
            end
            if (i_cmd.dec_wait) begin
                r_wait_cnt <= r_wait_cnt - 16'd1;
            end
            if (i_cmd.emit) begin
                if (w_is_last) begin
                    r_wait_cnt <= '0;
                end else begin
                    r_step_idx <= r_step_idx + 8'd1;
                    r_wait_cnt <= (r_step_wait == 16'd0) ? 16'd1 : r_step_wait;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_f) begin
            r_f <= ({r_step_idx, 1'b0} < S_W9) ? w_f_lo[15:0] : w_f_hi[15:0];
        end
        if (i_cmd.take_pos) begin
            r_pos <= w_quo[7:0];
        end
        if (i_cmd.div_start && (i_cmd.div_sel == DIV_MAP)) begin
            r_neg <= w_map_prod[24];
        end
        if (i_cmd.emit) begin
            r_cmp      <= r_neg ? (r_min - w_q16) : (r_min + w_q16);
            r_step_num <= r_step_idx;
            r_last     <= w_is_last;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.wait_gt1 = (r_wait_cnt > 16'd1);
    assign o_sts.is_last  = w_is_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_compare_value = r_cmp;
    assign o_step_number   = r_step_num;
    assign o_last_step     = r_last;
endmodule

// File: sv/seio_chk.sv
`include "servo_ease_in_out_profile_defines.svh"

module seio_chk #(
    parameter int unsigned STEP_COUNT = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_opcode,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_compare_value,
    input  logic [7:0]  i_step_number,
    input  logic        i_last_step
);
    import seio_pkg::*;

    localparam logic [7:0] S_W8 = 8'(STEP_COUNT);

    `SEIO_ASSERT_NOW(a_step_range, i_out_valid, i_step_number <= S_W8, "step beyond count")

    `SEIO_ASSERT_NOW(a_last_flag, i_out_valid, i_last_step == (i_step_number == S_W8), "last flag wrong")

    `SEIO_ASSERT_NEXT(a_start_busy, i_in_valid && i_in_ready && (i_in_opcode == OP_START), !i_in_ready, "ready after start")

    `SEIO_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_compare_value) && $stable(i_step_number), "result dropped")
endmodule

bind servo_ease_in_out_profile seio_chk #(
    .STEP_COUNT (STEP_COUNT)
) u_seio_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_opcode     (i_in.opcode),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_compare_value (o_out.compare_value),
    .i_step_number   (o_out.step_number),
    .i_last_step     (o_out.last_step)
);
